/* hdl/jkvl_pkg.sv */
// Shared types, codes and character constants of the JSON key/value locator.
`timescale 1ns / 1ps
`default_nettype none

package jkvl_pkg;

  // Default sizing
  localparam int unsigned MAX_TEXT_BYTES_DEF = 4096;
  localparam int unsigned KEY_BYTES_DEF      = 16;

  // Fixed field widths
  localparam int unsigned KEY_LEN_W  = 5;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_LANE_BYTES = 8;

  // Characters the scanner reacts to
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;

  // Scanner phases
  typedef enum logic [2:0] {
    PH_OUTSIDE,
    PH_IN_NAME,
    PH_NAME_ESC,
    PH_AFTER_NAME,
    PH_WAIT_VALUE,
    PH_IN_VALUE,
    PH_VALUE_ESC,
    PH_DONE
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_FOUND  = 3'd0,
    ST_ABSENT = 3'd1,
    ST_UNTERM = 3'd2,
    ST_TYPE   = 3'd3,
    ST_LONG   = 3'd4
  } status_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW,
    CFG_KEY_HIGH,
    CFG_KEY_LEN,
    CFG_VALUE_KIND
  } cfg_reg_e;

  // One text byte as held in the input register
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } byte_word_t;

  // Scalar configuration fields
  typedef struct packed {
    logic [KEY_LEN_W-1:0] key_length;
    logic                 value_kind;
  } cfg_t;

  // One result word
  typedef struct packed {
    status_e              status;
    logic [OFFSET_W-1:0]  value_start;
    logic [OFFSET_W-1:0]  value_end;
  } result_t;

  // 0x01..0x20 count as white space
  function automatic logic is_white(input logic [7:0] b);
    return (b != CH_NUL) && (b <= CH_SPACE);
  endfunction

endpackage

`default_nettype wire

/* hdl/jkvl_in_stage.sv */
// Input register: holds one text byte until the scanner takes it.
`timescale 1ns / 1ps
`default_nettype none

module jkvl_in_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           text_byte_i,
  input  wire logic                 last_i,
  output logic                      word_valid_o,
  output jkvl_pkg::byte_word_t      word_o,
  input  wire logic                 take_i
);

  logic                 valid_q, valid_d;
  jkvl_pkg::byte_word_t word_q;
  logic                 accept;

  // Free when empty or when the held word leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q.text_byte <= text_byte_i;
      word_q.last      <= last_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

`default_nettype wire

/* hdl/jkvl_cfg.sv */
// Configuration registers: key bytes, key length and expected value kind.
`timescale 1ns / 1ps
`default_nettype none

module jkvl_cfg #(
  parameter int unsigned KEY_BYTES = jkvl_pkg::KEY_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [jkvl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [jkvl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [KEY_BYTES*8-1:0]                 key_o,
  output jkvl_pkg::cfg_t                         cfg_o
);

  logic [KEY_BYTES*8-1:0] key_q;
  jkvl_pkg::cfg_t         cfg_q;

  // Only the key bytes that can be compared are stored
  for (genvar i = 0; i < KEY_BYTES; i++) begin : g_key
    localparam jkvl_pkg::cfg_reg_e Reg =
      (i < jkvl_pkg::CFG_LANE_BYTES) ? jkvl_pkg::CFG_KEY_LOW : jkvl_pkg::CFG_KEY_HIGH;
    localparam int unsigned Lane = i % jkvl_pkg::CFG_LANE_BYTES;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        key_q[8*i +: 8] <= 8'h00;
      end else if (cfg_valid_i && (cfg_index_i == Reg)) begin
        key_q[8*i +: 8] <= cfg_data_i[8*Lane +: 8];
      end
    end
  end

  // Scalar fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_length <= '0;
      cfg_q.value_kind <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        jkvl_pkg::CFG_KEY_LEN: begin
          cfg_q.key_length <= cfg_data_i[jkvl_pkg::KEY_LEN_W-1:0];
        end
        jkvl_pkg::CFG_VALUE_KIND: begin
          cfg_q.value_kind <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign key_o = key_q;
  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/jkvl_scan.sv */
// Scanner: per-byte phase update, key compare and result formation.
`timescale 1ns / 1ps
`default_nettype none

module jkvl_scan #(
  parameter int unsigned MAX_TEXT_BYTES = jkvl_pkg::MAX_TEXT_BYTES_DEF,
  parameter int unsigned KEY_BYTES      = jkvl_pkg::KEY_BYTES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [KEY_BYTES*8-1:0] key_i,
  input  wire jkvl_pkg::cfg_t         cfg_i,
  input  wire logic                   word_valid_i,
  input  wire jkvl_pkg::byte_word_t   word_i,
  input  wire logic                   res_room_i,
  output logic                        take_o,
  output logic                        res_load_o,
  output jkvl_pkg::result_t           res_o
);

  localparam int unsigned PW = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned KW = jkvl_pkg::KEY_LEN_W;
  localparam int unsigned OW = jkvl_pkg::OFFSET_W;

  // State
  jkvl_pkg::phase_e  phase_q, phase_d, phase_take;
  logic [PW-1:0]     pos_q, pos_d;
  logic [KW-1:0]     key_idx_q, key_idx_d, key_idx_take;
  logic              match_q, match_d, match_take;
  logic [OW-1:0]     vstart_q, vstart_d, vstart_take;
  logic [OW-1:0]     vend_q, vend_d, vend_take;
  jkvl_pkg::status_e outcome_q, outcome_d, outcome_take, outcome_fin;
  logic              too_long_q, too_long_d, too_long_fin;

  logic [7:0]        b;
  logic              in_range;
  logic              byte_on;
  logic [7:0]        key_sel;
  logic              cmp_ok;
  logic              wait_open_ok;
  logic [OW-1:0]     pos_off;

  assign b        = word_i.text_byte;
  assign take_o   = word_valid_i && (!word_i.last || res_room_i);
  assign in_range = pos_q < PW'(MAX_TEXT_BYTES);
  assign byte_on  = take_o && in_range && (phase_q != jkvl_pkg::PH_DONE);
  assign pos_off  = OW'(pos_q);

  // Key byte at the current compare index
  always_comb begin
    key_sel = 8'h00;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (key_idx_q == KW'(i)) begin
        key_sel = key_i[8*i +: 8];
      end
    end
  end

  assign cmp_ok = match_q && (key_idx_q < cfg_i.key_length) &&
                  (key_idx_q < KW'(KEY_BYTES)) && (b == key_sel);

  assign wait_open_ok = cfg_i.value_kind ? (b == jkvl_pkg::CH_LBRACKET)
                                         : (b == jkvl_pkg::CH_QUOTE);

  // Next phase for the byte
  always_comb begin
    phase_take = phase_q;
    if (byte_on) begin
      if (b == jkvl_pkg::CH_NUL) begin
        phase_take = jkvl_pkg::PH_DONE;
      end else begin
        case (phase_q)
          jkvl_pkg::PH_OUTSIDE: begin
            if (b == jkvl_pkg::CH_QUOTE) phase_take = jkvl_pkg::PH_IN_NAME;
          end
          jkvl_pkg::PH_IN_NAME: begin
            if (b == jkvl_pkg::CH_QUOTE) begin
              phase_take = jkvl_pkg::PH_AFTER_NAME;
            end else if (b == jkvl_pkg::CH_BSLASH) begin
              phase_take = jkvl_pkg::PH_NAME_ESC;
            end
          end
          jkvl_pkg::PH_NAME_ESC: begin
            phase_take = jkvl_pkg::PH_IN_NAME;
          end
          jkvl_pkg::PH_AFTER_NAME: begin
            if (jkvl_pkg::is_white(b)) begin
              phase_take = jkvl_pkg::PH_AFTER_NAME;
            end else if (b == jkvl_pkg::CH_COLON) begin
              phase_take = (match_q && (key_idx_q == cfg_i.key_length))
                           ? jkvl_pkg::PH_WAIT_VALUE : jkvl_pkg::PH_OUTSIDE;
            end else if (b == jkvl_pkg::CH_QUOTE) begin
              phase_take = jkvl_pkg::PH_IN_NAME;
            end else begin
              phase_take = jkvl_pkg::PH_OUTSIDE;
            end
          end
          jkvl_pkg::PH_WAIT_VALUE: begin
            if (jkvl_pkg::is_white(b)) begin
              phase_take = jkvl_pkg::PH_WAIT_VALUE;
            end else if (wait_open_ok && !cfg_i.value_kind) begin
              phase_take = jkvl_pkg::PH_IN_VALUE;
            end else begin
              phase_take = jkvl_pkg::PH_DONE;
            end
          end
          jkvl_pkg::PH_IN_VALUE: begin
            if (b == jkvl_pkg::CH_BSLASH) begin
              phase_take = jkvl_pkg::PH_VALUE_ESC;
            end else if (b == jkvl_pkg::CH_QUOTE) begin
              phase_take = jkvl_pkg::PH_DONE;
            end
          end
          jkvl_pkg::PH_VALUE_ESC: begin
            phase_take = jkvl_pkg::PH_IN_VALUE;
          end
          default: begin
            phase_take = phase_q;
          end
        endcase
      end
    end
  end

  // Last byte closes the text and the scanner starts over
  always_comb begin
    phase_d = phase_q;
    if (take_o) begin
      phase_d = word_i.last ? jkvl_pkg::PH_OUTSIDE : phase_take;
    end
  end

  // Key tracking, offsets and outcome for the byte
  always_comb begin
    key_idx_take = key_idx_q;
    match_take   = match_q;
    vstart_take  = vstart_q;
    vend_take    = vend_q;
    outcome_take = outcome_q;
    if (byte_on) begin
      if (b == jkvl_pkg::CH_NUL) begin
        // early end: judge the phase the zero byte interrupts
        case (phase_q)
          jkvl_pkg::PH_IN_NAME, jkvl_pkg::PH_NAME_ESC,
          jkvl_pkg::PH_IN_VALUE, jkvl_pkg::PH_VALUE_ESC: begin
            outcome_take = jkvl_pkg::ST_UNTERM;
          end
          jkvl_pkg::PH_WAIT_VALUE: begin
            outcome_take = jkvl_pkg::ST_TYPE;
          end
          default: begin
          end
        endcase
      end else begin
        case (phase_q)
          jkvl_pkg::PH_OUTSIDE, jkvl_pkg::PH_AFTER_NAME: begin
            // a quote opens a new name here (after-name only when not white)
            if (b == jkvl_pkg::CH_QUOTE) begin
              key_idx_take = '0;
              match_take   = 1'b1;
            end
          end
          jkvl_pkg::PH_IN_NAME, jkvl_pkg::PH_NAME_ESC: begin
            if ((phase_q == jkvl_pkg::PH_NAME_ESC) || (b != jkvl_pkg::CH_QUOTE)) begin
              if (cmp_ok) begin
                key_idx_take = key_idx_q + KW'(1);
              end else begin
                match_take = 1'b0;
              end
            end
          end
          jkvl_pkg::PH_WAIT_VALUE: begin
            if (!jkvl_pkg::is_white(b)) begin
              if (wait_open_ok) begin
                vstart_take = pos_off;
                if (cfg_i.value_kind) begin
                  vend_take    = pos_off;
                  outcome_take = jkvl_pkg::ST_FOUND;
                end
              end else begin
                outcome_take = jkvl_pkg::ST_TYPE;
              end
            end
          end
          jkvl_pkg::PH_IN_VALUE: begin
            if (b == jkvl_pkg::CH_QUOTE) begin
              vend_take    = pos_off;
              outcome_take = jkvl_pkg::ST_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // End-of-text judgment and the result word
  always_comb begin
    case (phase_take)
      jkvl_pkg::PH_IN_NAME, jkvl_pkg::PH_NAME_ESC,
      jkvl_pkg::PH_IN_VALUE, jkvl_pkg::PH_VALUE_ESC: begin
        outcome_fin = jkvl_pkg::ST_UNTERM;
      end
      jkvl_pkg::PH_WAIT_VALUE: begin
        outcome_fin = jkvl_pkg::ST_TYPE;
      end
      default: begin
        outcome_fin = outcome_take;
      end
    endcase
    too_long_fin = too_long_q || !in_range;
    res_o.status = too_long_fin ? jkvl_pkg::ST_LONG : outcome_fin;
    if (res_o.status == jkvl_pkg::ST_FOUND) begin
      res_o.value_start = vstart_take;
      res_o.value_end   = vend_take;
    end else begin
      res_o.value_start = '0;
      res_o.value_end   = '0;
    end
    res_load_o = take_o && word_i.last;
  end

  // Data next values
  always_comb begin
    pos_d      = pos_q;
    key_idx_d  = key_idx_q;
    match_d    = match_q;
    vstart_d   = vstart_q;
    vend_d     = vend_q;
    outcome_d  = outcome_q;
    too_long_d = too_long_q;
    if (take_o && word_i.last) begin
      pos_d      = '0;
      key_idx_d  = '0;
      match_d    = 1'b1;
      vstart_d   = '0;
      vend_d     = '0;
      outcome_d  = jkvl_pkg::ST_ABSENT;
      too_long_d = 1'b0;
    end else if (take_o) begin
      pos_d      = in_range ? (pos_q + PW'(1)) : pos_q;
      key_idx_d  = key_idx_take;
      match_d    = match_take;
      vstart_d   = vstart_take;
      vend_d     = vend_take;
      outcome_d  = outcome_take;
      too_long_d = too_long_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= jkvl_pkg::PH_OUTSIDE;
      pos_q      <= '0;
      key_idx_q  <= '0;
      match_q    <= 1'b1;
      vstart_q   <= '0;
      vend_q     <= '0;
      outcome_q  <= jkvl_pkg::ST_ABSENT;
      too_long_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      key_idx_q  <= key_idx_d;
      match_q    <= match_d;
      vstart_q   <= vstart_d;
      vend_q     <= vend_d;
      outcome_q  <= outcome_d;
      too_long_q <= too_long_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/jkvl_out_stage.sv */
// Result register: holds one result word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module jkvl_out_stage (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             load_i,
  input  wire jkvl_pkg::result_t                res_i,
  output logic                                  room_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [2:0]                            status_o,
  output logic [jkvl_pkg::OFFSET_W-1:0]         value_start_o,
  output logic [jkvl_pkg::OFFSET_W-1:0]         value_end_o
);

  logic              valid_q, valid_d;
  jkvl_pkg::result_t res_q;

  // Room when empty or when the held word is taken now
  assign room_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign status_o      = res_q.status;
  assign value_start_o = res_q.value_start;
  assign value_end_o   = res_q.value_end;

endmodule

`default_nettype wire

/* hdl/json_key_value_locator.sv */
// Top level of the JSON key/value locator.
//
// Usage: a JSON text streams in one byte per word on the in channel
// (text_byte_i, last_i set on the final byte). The block finds the first
// quoted name equal to the configured key and followed by a colon, checks
// that the value opens with a quote or a bracket, and returns one result
// word per text on the out channel: status, value_start and value_end.
// Config is written on the cfg channel (index 0/1 key bytes, 2 key length,
// 3 value kind) while no text is in flight: the user must keep to this,
// since the block does not enforce it. cfg_ready_o is always high.
// Throughput: one byte per cycle while the result register has room for a
// last byte, set by the combinational phase update and key-byte compare
// between the input register and the result register.
// Reset clears the scanner, the key, key length and value kind, and both
// stages. When the receiver stalls, the result register holds its word;
// plain bytes keep flowing, and a last byte waits in the input register
// until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module json_key_value_locator #(
  parameter int unsigned MAX_TEXT_BYTES = jkvl_pkg::MAX_TEXT_BYTES_DEF,
  parameter int unsigned KEY_BYTES      = jkvl_pkg::KEY_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [7:0]                        text_byte_i,
  input  wire logic                              last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [2:0]                             status_o,
  output logic [jkvl_pkg::OFFSET_W-1:0]          value_start_o,
  output logic [jkvl_pkg::OFFSET_W-1:0]          value_end_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [jkvl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [jkvl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                   word_valid;
  jkvl_pkg::byte_word_t   word;
  logic                   take;
  logic                   res_load;
  logic                   res_room;
  jkvl_pkg::result_t      res;
  logic [KEY_BYTES*8-1:0] key;
  jkvl_pkg::cfg_t         cfg;

  assign cfg_ready_o = 1'b1;

  jkvl_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .last_i       (last_i),
    .word_valid_o (word_valid),
    .word_o       (word),
    .take_i       (take)
  );

  jkvl_cfg #(
    .KEY_BYTES (KEY_BYTES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key),
    .cfg_o       (cfg)
  );

  jkvl_scan #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
    .KEY_BYTES      (KEY_BYTES)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key),
    .cfg_i        (cfg),
    .word_valid_i (word_valid),
    .word_i       (word),
    .res_room_i   (res_room),
    .take_o       (take),
    .res_load_o   (res_load),
    .res_o        (res)
  );

  jkvl_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_load),
    .res_i         (res),
    .room_o        (res_room),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .value_start_o (value_start_o),
    .value_end_o   (value_end_o)
  );

endmodule

`default_nettype wire

/* hdl/jkvl_checker.sv */
// Port-level checks of the JSON key/value locator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module jkvl_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              last_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [2:0]                        status_o,
  input wire logic [jkvl_pkg::OFFSET_W-1:0]     value_start_o,
  input wire logic [jkvl_pkg::OFFSET_W-1:0]     value_end_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(value_start_o) && $stable(value_end_o)))
    else $error("result word changed while stalled");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == jkvl_pkg::ST_FOUND || status_o == jkvl_pkg::ST_ABSENT ||
                     status_o == jkvl_pkg::ST_UNTERM || status_o == jkvl_pkg::ST_TYPE ||
                     status_o == jkvl_pkg::ST_LONG))
    else $error("undefined status code");

  // Offsets are zero on every failure
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != jkvl_pkg::ST_FOUND)) |->
      ((value_start_o == '0) && (value_end_o == '0)))
    else $error("nonzero offsets on a failed lookup");

  // A fresh result follows a last byte taken on the input channel
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_i, 2))
    else $error("result word without a closing byte");

endmodule

bind json_key_value_locator jkvl_checker u_jkvl_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for json_key_value_locator: streamed texts against a scan predictor.
`timescale 1ns / 1ps

module tb_top;
  import jkvl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TEXT_LIMIT   = MAX_TEXT_BYTES_DEF;
  localparam int unsigned KEY_LIMIT    = KEY_BYTES_DEF;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_BYTES  = 140;

  // Ports of the block
  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [7:0]            text_byte_i;
  logic                  last_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [2:0]            status_o;
  logic [OFFSET_W-1:0]   value_start_o;
  logic [OFFSET_W-1:0]   value_end_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  json_key_value_locator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .value_start_o (value_start_o),
    .value_end_o   (value_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Scan predictor plus queue of pending lookup results
  class locator_scoreboard;
    logic [63:0]          key_lo;
    logic [63:0]          key_hi;
    logic [KEY_LEN_W-1:0] key_len;
    logic                 want_array;
    phase_e               phase;
    int unsigned          offset;
    int unsigned          key_idx;
    bit                   name_ok;
    logic [11:0]          vstart;
    logic [11:0]          vend;
    status_e              outcome;
    bit                   overflow;
    result_t              lookup_q[$];
    int unsigned          errors;

    function new();
      key_lo     = '0;
      key_hi     = '0;
      key_len    = '0;
      want_array = 1'b0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_OUTSIDE;
      offset   = 0;
      key_idx  = 0;
      name_ok  = 1'b1;
      vstart   = '0;
      vend     = '0;
      outcome  = ST_ABSENT;
      overflow = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] d);
      case (idx)
        CFG_KEY_LOW:    key_lo = d;
        CFG_KEY_HIGH:   key_hi = d;
        CFG_KEY_LEN:    key_len = d[KEY_LEN_W-1:0];
        CFG_VALUE_KIND: want_array = d[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] key_char(int unsigned i);
      if (i < 8) return key_lo[8*i +: 8];
      return key_hi[8*(i-8) +: 8];
    endfunction

    function bit blank_byte(logic [7:0] b);
      return (b != CH_NUL) && (b <= CH_SPACE);
    endfunction

    function void open_name();
      phase   = PH_IN_NAME;
      key_idx = 0;
      name_ok = 1'b1;
    endfunction

    function void match_name_byte(logic [7:0] b);
      if (name_ok && key_idx < key_len && key_idx < KEY_LIMIT && b == key_char(key_idx))
        key_idx++;
      else
        name_ok = 1'b0;
    endfunction

    // Zero byte or end of text: open strings and missing values decide the outcome
    function void close_scan();
      case (phase)
        PH_IN_NAME, PH_NAME_ESC, PH_IN_VALUE, PH_VALUE_ESC: outcome = ST_UNTERM;
        PH_WAIT_VALUE: outcome = ST_TYPE;
        default: ;
      endcase
      phase = PH_DONE;
    endfunction

    function void scan_byte(logic [7:0] b, logic [11:0] p);
      if (phase == PH_DONE) return;
      if (b == CH_NUL) begin
        close_scan();
        return;
      end
      case (phase)
        PH_OUTSIDE: if (b == CH_QUOTE) open_name();
        PH_IN_NAME: begin
          if (b == CH_QUOTE) begin
            phase = PH_AFTER_NAME;
          end else begin
            match_name_byte(b);
            if (b == CH_BSLASH) phase = PH_NAME_ESC;
          end
        end
        PH_NAME_ESC: begin
          match_name_byte(b);
          phase = PH_IN_NAME;
        end
        PH_AFTER_NAME: begin
          if (blank_byte(b)) begin
          end else if (b == CH_COLON) begin
            phase = (name_ok && key_idx == key_len) ? PH_WAIT_VALUE : PH_OUTSIDE;
          end else if (b == CH_QUOTE) begin
            open_name();
          end else begin
            phase = PH_OUTSIDE;
          end
        end
        PH_WAIT_VALUE: begin
          if (blank_byte(b)) begin
          end else if (!want_array && b == CH_QUOTE) begin
            vstart = p;
            phase  = PH_IN_VALUE;
          end else if (want_array && b == CH_LBRACKET) begin
            vstart  = p;
            vend    = p;
            outcome = ST_FOUND;
            phase   = PH_DONE;
          end else begin
            outcome = ST_TYPE;
            phase   = PH_DONE;
          end
        end
        PH_IN_VALUE: begin
          if (b == CH_BSLASH) begin
            phase = PH_VALUE_ESC;
          end else if (b == CH_QUOTE) begin
            vend    = p;
            outcome = ST_FOUND;
            phase   = PH_DONE;
          end
        end
        PH_VALUE_ESC: phase = PH_IN_VALUE;
        default: ;
      endcase
    endfunction

    // Accepted input word: advance the scan, queue a result on the last byte
    function void note_word(logic [7:0] b, logic is_last);
      result_t r;
      if (offset >= TEXT_LIMIT) begin
        overflow = 1'b1;
      end else begin
        scan_byte(b, offset[11:0]);
        offset++;
      end
      if (is_last) begin
        close_scan();
        r.status      = overflow ? ST_LONG : outcome;
        r.value_start = (r.status == ST_FOUND) ? vstart : '0;
        r.value_end   = (r.status == ST_FOUND) ? vend : '0;
        lookup_q.push_back(r);
        restart();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [2:0] st, logic [11:0] vs, logic [11:0] ve);
      result_t exp_r;
      if (lookup_q.size() == 0) begin
        report($sformatf("result with none pending: status %0d", st));
        return;
      end
      exp_r = lookup_q.pop_front();
      if (st !== exp_r.status)
        report($sformatf("status %0d, want %0d", st, exp_r.status));
      if (vs !== exp_r.value_start)
        report($sformatf("value_start %0d, want %0d", vs, exp_r.value_start));
      if (ve !== exp_r.value_end)
        report($sformatf("value_end %0d, want %0d", ve, exp_r.value_end));
    endtask
  endclass

  locator_scoreboard sb;

  // Stimulus state
  logic [7:0]           txt[$];
  logic [63:0]          cur_key_lo;
  logic [63:0]          cur_key_hi;
  int unsigned          cur_len;
  bit                   in_offer;
  bit                   hold_request;
  int unsigned          burst_mode;
  int unsigned          burst_left;
  int unsigned          cycle_count;
  int unsigned          plan_len[10] = '{1, 16, 0, 31, 5, 16, 17, 8, 3, 12};

  // Clock, period 2 ns
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Text construction helpers
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h61;
    return b;
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void push_ws();
    repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom_range(1, 32)));
  endfunction

  // String body with escape pairs mixed in
  function automatic void push_content(int unsigned max_n);
    repeat ($urandom_range(0, max_n)) begin
      if ($urandom_range(0, 7) == 0) begin
        txt.push_back(CH_BSLASH);
        txt.push_back(8'($urandom_range(1, 255)));
      end else begin
        txt.push_back(plain_byte());
      end
    end
  endfunction

  function automatic logic [7:0] cur_key_byte(int unsigned i);
    if (i < 8) return cur_key_lo[8*i +: 8];
    return cur_key_hi[8*(i-8) +: 8];
  endfunction

  function automatic void key_put(int unsigned i, logic [7:0] v);
    if (i < 8) cur_key_lo[8*i +: 8] = v;
    else cur_key_hi[8*(i-8) +: 8] = v;
  endfunction

  // Random key registers; first bytes form a raw name, escapes kept in pairs
  function automatic void fill_key(int unsigned len);
    int unsigned n;
    int unsigned i;
    cur_key_lo = {$urandom, $urandom};
    cur_key_hi = {$urandom, $urandom};
    cur_len    = len;
    n = (len > KEY_LIMIT) ? KEY_LIMIT : len;
    i = 0;
    while (i < n) begin
      if (i + 1 < n && $urandom_range(0, 7) == 0) begin
        key_put(i, CH_BSLASH);
        key_put(i + 1, 8'($urandom_range(1, 255)));
        i += 2;
      end else begin
        key_put(i, plain_byte());
        i++;
      end
    end
  endfunction

  // Name: the key, the key plus a byte, the key with its last byte changed, or random
  function automatic void push_name();
    int unsigned r;
    int unsigned n;
    logic [7:0]  b;
    r = $urandom_range(0, 19);
    n = (cur_len > KEY_LIMIT) ? KEY_LIMIT : cur_len;
    txt.push_back(CH_QUOTE);
    if (r < 13) begin
      for (int i = 0; i < n; i++) txt.push_back(cur_key_byte(i));
      if (r >= 7 && r < 10) begin
        txt.push_back(8'h78);
      end else if (r >= 10) begin
        if (n == 0) begin
          txt.push_back(8'h71);
        end else begin
          b = txt[txt.size()-1] ^ 8'h01;
          if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h71;
          txt[txt.size()-1] = b;
        end
      end
    end else begin
      push_content(6);
    end
    txt.push_back(CH_QUOTE);
  endfunction

  function automatic void push_value(int unsigned depth);
    case ($urandom_range(0, depth == 0 ? 5 : 4))
      0, 1: begin
        txt.push_back(CH_QUOTE);
        push_content(6);
        txt.push_back(CH_QUOTE);
      end
      2: begin
        txt.push_back(CH_LBRACKET);
        push_ws();
        if ($urandom_range(0, 1) == 1) begin
          txt.push_back(CH_QUOTE);
          push_content(3);
          txt.push_back(CH_QUOTE);
          txt.push_back(8'h2C);
        end
        txt.push_back(8'h37);
        txt.push_back(8'h5D);
      end
      3: repeat ($urandom_range(1, 3)) txt.push_back(8'(8'h30 + $urandom_range(0, 9)));
      4: push_str("true");
      default: begin
        txt.push_back(8'h7B);
        push_member(1);
        txt.push_back(8'h7D);
      end
    endcase
  endfunction

  function automatic void push_member(int unsigned depth);
    push_ws();
    push_name();
    push_ws();
    txt.push_back(CH_COLON);
    push_ws();
    push_value(depth);
    push_ws();
  endfunction

  // Mostly well-formed objects; about a third get damaged
  function automatic void build_text();
    int unsigned n;
    txt.delete();
    txt.push_back(8'h7B);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) txt.push_back(8'h2C);
      push_member(0);
    end
    txt.push_back(8'h7D);
    case ($urandom_range(0, 11))
      0: txt[$urandom_range(0, txt.size()-1)] = 8'($urandom_range(0, 255));
      1: begin
        n = $urandom_range(1, txt.size());
        while (txt.size() > n) void'(txt.pop_back());
      end
      2: txt[$urandom_range(0, txt.size()-1)] = CH_NUL;
      3: begin
        txt.delete();
        repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  // Input channel driving
  task automatic send_word(logic [7:0] b, logic is_last);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    in_offer     = 1'b1;
    text_byte_i <= b;
    last_i      <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(b, is_last);
    if (burst_mode != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, burst_mode == 3 ? 12 : 3);
        in_valid_i <= 1'b0;
        in_offer    = 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_text();
    burst_mode = $urandom_range(0, 3);
    for (int i = 0; i < txt.size(); i++) send_word(txt[i], i == txt.size() - 1);
  endtask

  task automatic send_str(string s);
    txt.delete();
    push_str(s);
    send_text();
  endtask

  task automatic pause_input();
    if (in_offer) begin
      in_valid_i <= 1'b0;
      in_offer    = 1'b0;
    end
  endtask

  // Hold the input until every pending result is back, plus the pipeline depth
  task automatic drain_results();
    pause_input();
    while (sb.lookup_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Config channel driving; valid stays up across a batch
  task automatic write_reg(cfg_reg_e idx, logic [63:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
  endtask

  task automatic load_settings(logic want_array);
    write_reg(CFG_KEY_LOW, cur_key_lo);
    write_reg(CFG_KEY_HIGH, cur_key_hi);
    write_reg(CFG_KEY_LEN, 64'(cur_len));
    write_reg(CFG_VALUE_KIND, 64'(want_array));
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: changing stall patterns plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned tick;
    int unsigned rx_mode;
    bit          ready_next;
    hold_left   = 0;
    mode_left   = 0;
    tick        = 0;
    rx_mode     = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(status_o, value_start_o, value_end_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_mode)
          0: ready_next = 1'b1;
          1: ready_next = ($urandom_range(0, 1) == 1);
          2: ready_next = (tick % 4 == 0);
          default: ready_next = ($urandom_range(0, 7) == 0);
        endcase
      end
      out_ready_i <= ready_next;
    end
  end

  // Main sequence
  initial begin
    int unsigned phase_bytes;
    int unsigned texts_sent;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    text_byte_i  = '0;
    last_i       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_KEY_LOW;
    cfg_data_i   = '0;
    in_offer     = 1'b0;
    hold_request = 1'b0;
    burst_mode   = 0;
    burst_left   = 0;
    cycle_count  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty key, string values
    send_str("\"\":\"\"");
    txt.delete();
    txt.push_back(CH_NUL);
    send_text();
    send_str("\"");
    send_str("\"\":5");
    send_str("\"\":");
    txt.delete();
    txt.push_back(8'hFF);
    send_text();
    send_str("\"\":\"\\\"");

    // Random texts under a series of key settings
    for (int ph = 0; ph < 10; ph++) begin
      drain_results();
      fill_key(plan_len[ph]);
      if (cur_len == 31) begin
        cur_key_lo = '1;
        cur_key_hi = '0;
      end
      load_settings(1'(ph == 9 ? $urandom_range(0, 1) : ph % 2));
      phase_bytes = 0;
      texts_sent  = 0;
      while (phase_bytes < PHASE_BYTES || texts_sent < 3) begin
        // long receiver hold while short texts keep coming
        if (ph == 2 && texts_sent == 1) hold_request = 1'b1;
        build_text();
        send_text();
        phase_bytes += txt.size();
        texts_sent++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* files.f */
hdl/jkvl_pkg.sv
hdl/jkvl_in_stage.sv
hdl/jkvl_cfg.sv
hdl/jkvl_scan.sv
hdl/jkvl_out_stage.sv
hdl/json_key_value_locator.sv
hdl/jkvl_checker.sv
tb/tb_top.sv
